// File: rtl/core/nbe_pkg.sv
`timescale 1ns / 1ps

package nbe_pkg;

   // Envelope is unsigned Q1.16; full level is 1.0.
   localparam logic [16:0] ENV_ONE   = 17'd65536;
   localparam logic [16:0] ENV_FLOOR = 17'd66;

   localparam logic [6:0] DRAW_MAX = 7'd99;
   localparam logic [6:0] DRAW_MID = 7'd50;

   // Reciprocals for division by constants, exact over the operand ranges used.
   // x / 100 for x below 2^22, x / 255 for x below 2^15, x / 10 for x below 2^11.
   localparam logic [22:0] RECIP_100       = 23'd5368710;
   localparam int          RECIP_100_SHIFT = 29;
   localparam logic [15:0] RECIP_255       = 16'd32897;
   localparam int          RECIP_255_SHIFT = 23;
   localparam logic [10:0] RECIP_10        = 11'd1639;
   localparam int          RECIP_10_SHIFT  = 14;

   typedef enum logic [1:0] {
      CSR_SURFACE     = 2'd0,
      CSR_VOLUME      = 2'd1,
      CSR_MOD_DEPTH   = 2'd2,
      CSR_ECHO_ENABLE = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      SURF_STONE = 3'd0,
      SURF_WATER = 3'd1,
      SURF_METAL = 3'd2,
      SURF_WOOD  = 3'd3,
      SURF_DIRT  = 3'd4
   } surface_type;

   typedef struct packed {
      logic [2:0]  surface;
      logic [7:0]  volume;
      logic [15:0] mod_depth;
      logic        echo_enable;
   } cfg_type;

   // One classified item handed from the front to the back.
   typedef struct packed {
      logic        trigger;
      logic [7:0]  noise;
      logic [16:0] mult;
   } job_type;

   localparam int JOB_W = $bits(job_type);

   // Decay rate per surface, Q0.16. Unused codes fall back to the wood rate.
   function automatic logic [10:0] surface_decay(input logic [2:0] code);
      logic [10:0] rate;
      unique case (surface_type'(code))
         SURF_STONE: rate = 11'd983;
         SURF_WATER: rate = 11'd328;
         SURF_METAL: rate = 11'd1966;
         SURF_WOOD:  rate = 11'd1311;
         SURF_DIRT:  rate = 11'd655;
         default:    rate = 11'd1311;
      endcase
      return rate;
   endfunction

endpackage

// File: rtl/core/nbe_fifo.sv
`timescale 1ns / 1ps

module nbe_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             push_ok;
   logic             pop_ok;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (push_ok && !pop_ok) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop_ok && !push_ok) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: rtl/core/nbe_front.sv
`timescale 1ns / 1ps

module nbe_front
   import nbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        accept,
   input  logic        trigger,
   input  logic [7:0]  noise,
   input  logic [6:0]  pitch_draw,
   output logic        busy,
   output logic        job_push,
   output job_type     job,
   input  logic        job_full
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_DIV,
      ST_MOD,
      ST_PUSH
   } state_type;

   state_type   state_ff;
   logic        trigger_ff;
   logic [7:0]  noise_ff;
   logic [5:0]  dmag_ff;
   logic        dneg_ff;
   logic [21:0] prodv_ff;
   logic [14:0] quot_ff;
   logic [27:0] dprod_ff;

   logic [6:0]  draw_sat;
   logic [44:0] quot_wide;
   logic [16:0] pmod;

   // Draws above the meaningful range saturate at the top value.
   assign draw_sat  = (pitch_draw > DRAW_MAX) ? DRAW_MAX : pitch_draw;
   assign quot_wide = 45'(prodv_ff) * 45'(RECIP_100);
   assign pmod      = dneg_ff ? (ENV_ONE - 17'(quot_ff)) : (ENV_ONE + 17'(quot_ff));

   assign busy     = (state_ff != ST_IDLE);
   assign job_push = (state_ff == ST_PUSH) && !job_full;
   assign job.trigger = trigger_ff;
   assign job.noise   = noise_ff;
   assign job.mult    = ENV_ONE - 17'(dprod_ff[27:16]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  trigger_ff <= trigger;
                  noise_ff   <= noise;
                  dneg_ff    <= (draw_sat < DRAW_MID);
                  dmag_ff    <= (draw_sat < DRAW_MID) ? 6'(DRAW_MID - draw_sat)
                                                      : 6'(draw_sat - DRAW_MID);
                  state_ff   <= ST_PROD;
               end
            end
            ST_PROD: begin
               prodv_ff <= 22'(cfg.mod_depth) * 22'(dmag_ff);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               // Magnitude divided by 100, truncating toward zero.
               quot_ff  <= quot_wide[RECIP_100_SHIFT +: 15];
               state_ff <= ST_MOD;
            end
            ST_MOD: begin
               dprod_ff <= 28'(surface_decay(cfg.surface)) * 28'(pmod);
               state_ff <= ST_PUSH;
            end
            ST_PUSH: begin
               if (!job_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/core/nbe_back.sv
`timescale 1ns / 1ps

module nbe_back
   import nbe_pkg::*;
#(
   parameter int ECHO_DEPTH = 512
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       job_empty,
   input  job_type    job,
   output logic       job_pop,
   input  logic       out_full,
   output logic       out_push,
   output logic [7:0] out_sample,
   output logic       clearing
);

   localparam int AW = $clog2(ECHO_DEPTH);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ENV,
      ST_SCALE,
      ST_DIV,
      ST_MIX
   } state_type;

   state_type   state_ff;
   job_type     job_ff;
   logic [16:0] env_ff;
   logic [15:0] magvol_ff;
   logic [14:0] hi_ff;
   logic [7:0]  smag_ff;
   logic [7:0]  rd_ff;
   logic [AW-1:0] pos_ff;
   logic [AW-1:0] clr_ff;
   logic [7:0]  echo_mem [ECHO_DEPTH];

   logic [16:0] env_src;
   logic [33:0] env_prod;
   logic [16:0] env_new;
   logic [7:0]  noise_mag;
   logic [31:0] scaled;
   logic [30:0] div255;
   logic signed [8:0]  s9;
   logic signed [11:0] mix;
   logic [10:0] mix_mag;
   logic [21:0] div10;
   logic [8:0]  q10;
   logic signed [8:0]  result;
   logic        mem_we;
   logic [AW-1:0] mem_wa;
   logic [7:0]  mem_wd;

   assign env_src   = job_ff.trigger ? ENV_ONE : env_ff;
   assign env_prod  = 34'(env_src) * 34'(job_ff.mult);
   assign env_new   = env_prod[32:16];
   assign noise_mag = job_ff.noise[7] ? (~job_ff.noise + 8'd1) : job_ff.noise;
   assign scaled    = 32'(magvol_ff) * 32'(env_ff);
   assign div255    = 31'(hi_ff) * 31'(RECIP_255);

   // Mix of the fresh sample with the delayed one, truncated toward zero.
   assign s9      = job_ff.noise[7] ? -$signed({1'b0, smag_ff}) : $signed({1'b0, smag_ff});
   assign mix     = 12'sd7 * 12'(s9) + 12'sd3 * 12'($signed(rd_ff));
   assign mix_mag = mix[11] ? 11'(-mix) : 11'(mix);
   assign div10   = 22'(mix_mag) * 22'(RECIP_10);
   assign q10     = {1'b0, div10[RECIP_10_SHIFT +: 8]};
   assign result  = !cfg.echo_enable ? s9 :
                    mix[11] ? -$signed(q10) : $signed(q10);

   assign clearing   = (state_ff == ST_CLEAR);
   assign job_pop    = (state_ff == ST_IDLE) && !job_empty && !out_full;
   assign out_push   = (state_ff == ST_MIX);
   assign out_sample = result[7:0];

   assign mem_we = clearing || ((state_ff == ST_MIX) && cfg.echo_enable);
   assign mem_wa = clearing ? clr_ff : pos_ff;
   assign mem_wd = clearing ? 8'd0 : result[7:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         echo_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= echo_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pos_ff   <= '0;
         env_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (clr_ff == AW'(ECHO_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  clr_ff <= clr_ff + AW'(1);
               end
            end
            ST_IDLE: begin
               if (job_pop) begin
                  job_ff   <= job;
                  state_ff <= ST_ENV;
               end
            end
            ST_ENV: begin
               env_ff    <= (env_new < ENV_FLOOR) ? '0 : env_new;
               magvol_ff <= 16'(noise_mag) * 16'(cfg.volume);
               state_ff  <= ST_SCALE;
            end
            ST_SCALE: begin
               // Dropping the low 16 bits first leaves the floor of the quotient intact.
               hi_ff    <= scaled[30:16];
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               smag_ff  <= div255[RECIP_255_SHIFT +: 8];
               state_ff <= ST_MIX;
            end
            ST_MIX: begin
               if (cfg.echo_enable) begin
                  pos_ff <= (pos_ff == AW'(ECHO_DEPTH - 1)) ? '0 : pos_ff + AW'(1);
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   env_bounded: assert property (@(posedge clock) disable iff (reset)
      env_ff <= ENV_ONE)
      else $error("envelope above full level");

   env_flushed: assert property (@(posedge clock) disable iff (reset)
      (env_ff == '0) || (env_ff >= ENV_FLOOR))
      else $error("envelope below flush floor but not zero");

   pos_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX && cfg.echo_enable) |=>
      (pos_ff == (($past(pos_ff) == AW'(ECHO_DEPTH - 1)) ? '0 : $past(pos_ff) + AW'(1))))
      else $error("delay index did not advance");

   pos_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX && !cfg.echo_enable) |=> $stable(pos_ff))
      else $error("delay index moved with echo off");

endmodule

// File: rtl/core/noise_burst_envelope_echo.sv
`timescale 1ns / 1ps

// Decaying noise burst with optional echo. Each item pushed on req_ carries a
// trigger bit, a signed noise byte and a random draw, and yields one signed
// 8-bit sample on rsp_; a trigger restarts the envelope at full level before
// that sample. A front stage works out the per-item decay factor (draw
// saturation, modulation divide, decay multiply) and hands it through a
// two-entry queue to a back stage that updates the envelope, scales the noise
// and mixes the echo, reading and writing the delay memory at one slot per
// item. Each stage works on one item at a time, and the front holds req_full
// high while it works, so no new item is accepted before the last one has
// been pushed into the job queue. A full result queue stalls the back stage,
// and through the job queue the front. After reset the delay memory is
// cleared one entry per cycle, and req_full stays high until it is clear.
// Registers must be written through csr_ only while no item is in flight;
// the block itself does not enforce this. The delay index moves only while
// echo is on.
module noise_burst_envelope_echo
   import nbe_pkg::*;
#(
   parameter int ECHO_DEPTH = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_trigger,
   input  logic signed [7:0] req_noise,
   input  logic [6:0]        req_pitch_draw,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic signed [7:0] rsp_sample,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   cfg_type    cfg_ff;
   logic       front_busy;
   logic       clearing;
   logic       accept;
   logic       job_push;
   logic       job_full;
   logic       job_empty;
   logic       job_pop;
   job_type    job_in;
   job_type    job_out;
   logic [JOB_W-1:0] job_rdata;
   logic       out_push;
   logic       out_full;
   logic [7:0] out_sample;
   logic [7:0] rsp_data;

   // Items are refused while the front is busy or the delay memory is being cleared.
   assign req_full   = front_busy || clearing;
   assign accept     = req_push && !req_full;
   assign job_out    = job_type'(job_rdata);
   assign rsp_sample = $signed(rsp_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.surface     <= 3'd0;
         cfg_ff.volume      <= 8'd128;
         cfg_ff.mod_depth   <= 16'd6554;
         cfg_ff.echo_enable <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_SURFACE:     cfg_ff.surface     <= csr_wdata[2:0];
            CSR_VOLUME:      cfg_ff.volume      <= csr_wdata[7:0];
            CSR_MOD_DEPTH:   cfg_ff.mod_depth   <= csr_wdata;
            CSR_ECHO_ENABLE: cfg_ff.echo_enable <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   nbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .trigger    (req_trigger),
      .noise      (req_noise),
      .pitch_draw (req_pitch_draw),
      .busy       (front_busy),
      .job_push   (job_push),
      .job        (job_in),
      .job_full   (job_full)
   );

   nbe_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (2)
   ) u_job_fifo (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .wdata (job_in),
      .full  (job_full),
      .pop   (job_pop),
      .rdata (job_rdata),
      .empty (job_empty)
   );

   nbe_back #(
      .ECHO_DEPTH (ECHO_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_empty  (job_empty),
      .job        (job_out),
      .job_pop    (job_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_sample (out_sample),
      .clearing   (clearing)
   );

   nbe_fifo #(
      .WIDTH (8),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_sample),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the noise burst generator. Items are pushed through
// the req_ queue interface, each one is run through a local copy of the
// envelope, gain and echo arithmetic at the moment it is accepted, and the
// expected sample is queued. Every sample popped from the rsp_ side is
// compared against the oldest expected one.
module tb_top;
   import nbe_pkg::*;

   localparam int ECHO_DEPTH     = 512;
   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 16;
   localparam int IDLE_PCT       = 37;
   localparam int FULL_LEVEL     = 65536;
   localparam int FLUSH_LEVEL    = 66;
   localparam int DRAW_TOP       = 99;
   localparam int DRAW_CENTER    = 50;
   localparam int NUM_PHASES     = 7;
   localparam int PHASE_ITEMS    = 80;
   localparam int FLUSH_ITEMS    = 200;

   logic              clock;
   logic              reset;
   logic              req_push;
   logic              req_full;
   logic              req_trigger;
   logic signed [7:0] req_noise;
   logic [6:0]        req_pitch_draw;
   logic              rsp_empty;
   logic              rsp_pop;
   logic signed [7:0] rsp_sample;
   logic              csr_write;
   logic [1:0]        csr_index;
   logic [15:0]       csr_wdata;

   // Shadow of the register file and of the block's internal state. These are
   // only touched while the block is idle (registers) or when an item is
   // accepted (envelope and delay line), so they stay in step with the design.
   cfg_type           active_cfg;
   longint            env_level;
   logic signed [7:0] echo_line [ECHO_DEPTH];
   int                echo_pos;
   int                decay_per_surface [8] = '{983, 328, 1966, 1311, 655, 1311, 1311, 1311};

   logic signed [7:0] expected_samples [$];
   int                errors;
   int                req_idle_pct;
   int                rsp_idle_pct;
   int                rsp_hold_cycles;

   noise_burst_envelope_echo #(
      .ECHO_DEPTH(ECHO_DEPTH)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_trigger   (req_trigger),
      .req_noise     (req_noise),
      .req_pitch_draw(req_pitch_draw),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_sample    (rsp_sample),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // 12 ns clock period.
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Advances the envelope by one tick and returns the sample that the block
   // should produce for this item. The draw saturates at the top of its range,
   // the modulation divide truncates toward zero, and a tiny envelope is
   // flushed to silence. With echo on the mixed sample is written back into
   // the delay line and the index wraps around its end.
   function automatic logic signed [7:0] next_echo_sample(input logic trig,
                                                          input logic signed [7:0] noise,
                                                          input logic [6:0] draw);
      int     draw_sat;
      int     mod_factor;
      int     level;
      int     delayed;
      longint decrement;
      longint gain;
      longint magnitude;
      longint scaled;
      draw_sat   = (int'(draw) > DRAW_TOP) ? DRAW_TOP : int'(draw);
      mod_factor = FULL_LEVEL
                 + (int'(active_cfg.mod_depth) * (draw_sat - DRAW_CENTER)) / 100;
      decrement  = (longint'(decay_per_surface[active_cfg.surface]) * mod_factor) >> 16;
      gain       = FULL_LEVEL - decrement;
      if (trig) begin
         env_level = FULL_LEVEL;
      end
      env_level = (env_level * gain) >> 16;
      if (env_level < FLUSH_LEVEL) begin
         env_level = 0;
      end
      magnitude = (noise < 0) ? -longint'(noise) : longint'(noise);
      scaled    = (magnitude * env_level * longint'(active_cfg.volume)) / (255 * 65536);
      level     = int'(scaled);
      if (noise < 0) begin
         level = -level;
      end
      if (active_cfg.echo_enable) begin
         delayed = echo_line[echo_pos];
         level = (7 * level + 3 * delayed) / 10;
         echo_line[echo_pos] = 8'(level);
         echo_pos = (echo_pos + 1) % ECHO_DEPTH;
      end
      return 8'(level);
   endfunction

   // Work out the expected sample at the very edge where an item is taken.
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         expected_samples.push_back(next_echo_sample(req_trigger, req_noise, req_pitch_draw));
      end
   end

   // Compare each popped sample with the oldest prediction.
   always @(posedge clock) begin : check_samples
      logic signed [7:0] want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_samples.size() == 0) begin
            $error("sample arrived with nothing expected: actual %0d", rsp_sample);
            errors++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample !== want) begin
               $error("sample mismatch: expected %0d, actual %0d", want, rsp_sample);
               errors++;
            end
         end
      end
   end

   // Result side. A hold-off request makes it refuse results until the hold-off
   // count has run down; otherwise it pops at random according to its idle rate.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_pop <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_pop <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Offers one item, with random idle cycles ahead of it, and returns at the
   // falling edge after it was taken. Push is left high so that the next item
   // can follow back to back.
   task automatic send_item(input logic trig, input logic signed [7:0] noise,
                            input logic [6:0] draw);
      while ($urandom_range(99) < req_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push       <= 1'b1;
      req_trigger    <= trig;
      req_noise      <= noise;
      req_pitch_draw <= draw;
      do begin
         @(posedge clock);
      end while (req_full);
      @(negedge clock);
   endtask

   // Stops offering items and waits until every expected sample has come back,
   // then lets the pipeline settle.
   task automatic wait_for_results();
      req_push <= 1'b0;
      while (expected_samples.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes all four registers, one per cycle, and mirrors them locally.
   task automatic apply_config(input cfg_type c);
      csr_index_type idx;
      logic [15:0]   data;
      for (int i = 0; i < 4; i++) begin
         idx = csr_index_type'(i);
         case (idx)
            CSR_SURFACE:     data = 16'(c.surface);
            CSR_VOLUME:      data = 16'(c.volume);
            CSR_MOD_DEPTH:   data = c.mod_depth;
            CSR_ECHO_ENABLE: data = 16'(c.echo_enable);
            default:         data = '0;
         endcase
         csr_write <= 1'b1;
         csr_index <= idx;
         csr_wdata <= data;
         @(negedge clock);
      end
      csr_write  <= 1'b0;
      active_cfg  = c;
   endtask

   function automatic logic [6:0] random_draw();
      // Mostly legal draws, with an occasional one above the top of the range.
      if ($urandom_range(7) == 0) begin
         return 7'($urandom_range(127));
      end
      return 7'($urandom_range(DRAW_TOP));
   endfunction

   // Runs a few items with the register values that reset leaves behind.
   task automatic test_reset_defaults();
      send_item(1'b1, 8'sd127, 7'd50);
      send_item(1'b0, -8'sd128, 7'd0);
      send_item(1'b0, 8'sd1, 7'd99);
      send_item(1'b1, -8'sd1, 7'd127);
   endtask

   // Full gain and full modulation depth with echo on, driving the noise and
   // the draw to their extremes, including draws above the legal range.
   task automatic test_field_extremes();
      cfg_type c;
      wait_for_results();
      c = '{surface: SURF_STONE, volume: 8'd255, mod_depth: 16'hFFFF, echo_enable: 1'b1};
      apply_config(c);
      send_item(1'b1, 8'sd127, 7'd0);
      send_item(1'b0, -8'sd128, 7'd99);
      send_item(1'b0, 8'sd127, 7'd100);
      send_item(1'b0, -8'sd128, 7'd127);
      send_item(1'b0, 8'sd0, 7'd64);
      send_item(1'b1, -8'sd1, 7'd50);
      send_item(1'b0, 8'sd85, 7'd42);
      send_item(1'b0, -8'sd86, 7'd21);
   endtask

   // One triggered tick for every surface code, the unnamed ones included;
   // those fall back to the wood decay rate.
   task automatic test_surface_codes();
      cfg_type c;
      for (int code = 0; code < 8; code++) begin
         wait_for_results();
         c = '{surface: 3'(code), volume: 8'd200, mod_depth: 16'd30000,
               echo_enable: 1'b0};
         apply_config(c);
         send_item(1'b1, -8'sd100, 7'd80);
      end
   endtask

   // The receiver holds off for a long stretch while items keep coming back
   // to back, so the block fills up and pushes back on its input. Then the
   // sender pauses until every sample is out.
   task automatic test_stall_recovery();
      wait_for_results();
      req_idle_pct    = 0;
      rsp_hold_cycles = 120;
      for (int i = 0; i < 30; i++) begin
         send_item(i % 6 == 0, 8'($urandom_range(255)), random_draw());
      end
      wait_for_results();
      req_idle_pct = IDLE_PCT;
   endtask

   // Bursts under a fresh register setting per phase. Triggers restart the
   // envelope every so often; one phase triggers once and lets a steep decay
   // run all the way down to the flush. Another phase runs with no idling on
   // either side.
   task automatic test_random_bursts();
      cfg_type    c;
      int         trig_period;
      int         count;
      logic       trig;
      logic [6:0] draw;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         c.surface     = 3'($urandom_range(7));
         c.echo_enable = (phase != 3);
         case ($urandom_range(2))
            0:       c.volume = 8'd255;
            1:       c.volume = 8'($urandom_range(255));
            default: c.volume = 8'($urandom_range(255, 100));
         endcase
         case ($urandom_range(2))
            0:       c.mod_depth = 16'hFFFF;
            1:       c.mod_depth = 16'd0;
            default: c.mod_depth = 16'($urandom_range(65535));
         endcase
         case ($urandom_range(2))
            0:       trig_period = 4;
            1:       trig_period = 25;
            default: trig_period = 120;
         endcase
         count = PHASE_ITEMS;
         if (phase == 1) begin
            // Steepest decay with no retrigger, so the envelope reaches the flush.
            c.surface   = SURF_METAL;
            c.mod_depth = 16'hFFFF;
            c.volume    = 8'd255;
            trig_period = 0;
            count       = FLUSH_ITEMS;
         end
         if (phase == 3) begin
            c.mod_depth = 16'd0;
         end
         if (phase == 5) begin
            c.volume = 8'd0;
         end
         wait_for_results();
         req_idle_pct = (phase == 4) ? 0 : IDLE_PCT;
         rsp_idle_pct = (phase == 4) ? 0 : IDLE_PCT;
         apply_config(c);
         for (int i = 0; i < count; i++) begin
            trig = (i == 0) || (trig_period > 0 && $urandom_range(trig_period - 1) == 0);
            draw = (phase == 1) ? 7'($urandom_range(127, 80)) : random_draw();
            send_item(trig, 8'($urandom_range(255)), draw);
         end
      end
      req_idle_pct = IDLE_PCT;
      rsp_idle_pct = IDLE_PCT;
   endtask

   initial begin
      reset           = 1'b1;
      req_push        = 1'b0;
      req_trigger     = 1'b0;
      req_noise       = '0;
      req_pitch_draw  = '0;
      rsp_pop         = 1'b0;
      csr_write       = 1'b0;
      csr_index       = CSR_SURFACE;
      csr_wdata       = '0;
      errors          = 0;
      req_idle_pct    = IDLE_PCT;
      rsp_idle_pct    = IDLE_PCT;
      rsp_hold_cycles = 0;
      active_cfg      = '{surface: SURF_STONE, volume: 8'd128, mod_depth: 16'd6554,
                          echo_enable: 1'b0};
      env_level       = 0;
      echo_pos        = 0;
      foreach (echo_line[i]) echo_line[i] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The block clears its delay memory after reset and holds req_full
      // meanwhile; the first item simply waits for it.
      test_reset_defaults();
      test_field_extremes();
      test_surface_codes();
      test_stall_recovery();
      test_random_bursts();
      wait_for_results();

      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/nbe_pkg.sv
rtl/core/nbe_fifo.sv
rtl/core/nbe_front.sv
rtl/core/nbe_back.sv
rtl/core/noise_burst_envelope_echo.sv
tb/tb_top.sv
